// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, disabled during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/llc_pkg.sv =====
// Shared types, constants and register codes of the latency calibrator.
package llc_pkg;

	localparam int unsigned SAMPLE_BITS        = 24;
	localparam int unsigned TEST_COUNT_DEFAULT = 4;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 24;
	localparam int unsigned S_TDATA_W   = 24;
	localparam int unsigned M_TDATA_W   = 80;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_NOISE_FRAMES   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PING_FRAMES    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PING_LEVEL     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ECHO_THRESHOLD = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_FRAMES = 3'd4;

	// defaults
	localparam logic [15:0] NOISE_FRAMES_DEFAULT   = 16'd1024;
	localparam logic [11:0] PING_FRAMES_DEFAULT    = 12'd64;
	localparam logic [23:0] PING_LEVEL_DEFAULT     = 24'd4194304;
	localparam logic [22:0] ECHO_THRESHOLD_DEFAULT = 23'd838861;
	localparam logic [17:0] TIMEOUT_FRAMES_DEFAULT = 18'd44100;

	localparam logic [17:0] LAT_MAX = 18'h3FFFF;
	localparam logic [22:0] SUM_MAX = 23'h7FFFFF;

	// reciprocal for the average: exact for any 23-bit sum and count up to 16
	localparam int unsigned RECIP_SHIFT = 28;
	localparam int unsigned RECIP_W     = 29;
	localparam int unsigned AVG_W       = 18;

	typedef struct packed {
		logic [15:0]                   noise_frames;
		logic [11:0]                   ping_frames;
		logic signed [SAMPLE_BITS-1:0] ping_level;
		logic [22:0]                   echo_threshold;
		logic [17:0]                   timeout_frames;
	} cfg_t;

	typedef struct packed {
		logic [31:0]            frame_count;
		logic [SAMPLE_BITS-1:0] peak_noise;
		logic [31:0]            ping_start;
		logic                   ping_pending;
		logic [4:0]             test_index;
		logic [22:0]            latency_sum;
		logic                   running;
		logic                   timeout_flag;
	} state_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_sample;
		logic                          busy_res;
		logic                          finished_ok;
		logic                          timed_out;
		logic [SAMPLE_BITS-1:0]        noise_floor;
		logic [4:0]                    measurements;
		logic [22:0]                   latency_sum;
	} result_t;

	localparam cfg_t CFG_RESET = '{
		noise_frames:   NOISE_FRAMES_DEFAULT,
		ping_frames:    PING_FRAMES_DEFAULT,
		ping_level:     PING_LEVEL_DEFAULT,
		echo_threshold: ECHO_THRESHOLD_DEFAULT,
		timeout_frames: TIMEOUT_FRAMES_DEFAULT
	};

	localparam state_t STATE_RESET = '{
		frame_count:  32'd0,
		peak_noise:   '0,
		ping_start:   32'd0,
		ping_pending: 1'b0,
		test_index:   5'd0,
		latency_sum:  23'd0,
		running:      1'b1,
		timeout_flag: 1'b0
	};

endpackage

// ===== rtl/llc_step.sv =====
// Per-frame next-state and result logic of the latency calibrator.
module llc_step import llc_pkg::*; #(
	parameter int unsigned TEST_COUNT = TEST_COUNT_DEFAULT
) (
	input  cfg_t                          cfg,
	input  state_t                        st,
	input  logic                          restart,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output state_t                        nxt,
	output result_t                       res
);

	localparam logic [4:0] TC = 5'(TEST_COUNT);

	always_comb begin
		state_t                 cur;
		logic [SAMPLE_BITS-1:0] raw;
		logic [SAMPLE_BITS-1:0] mag;
		logic [31:0]            delta;
		logic [31:0]            play_delta;
		logic [17:0]            lat;
		logic [23:0]            sum_wide;
		logic [4:0]             idx_inc;

		cur = restart ? STATE_RESET : st;
		nxt = cur;

		raw = $unsigned(sample);
		mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

		delta    = cur.frame_count - cur.ping_start;
		lat      = (delta > {14'd0, LAT_MAX}) ? LAT_MAX : delta[17:0];
		sum_wide = {1'b0, cur.latency_sum} + {6'd0, lat};
		idx_inc  = cur.test_index + 5'd1;

		if (cur.running) begin
			if (cur.frame_count < {16'd0, cfg.noise_frames}) begin
				if (mag > cur.peak_noise)
					nxt.peak_noise = mag;
			end else begin
				if (cur.ping_pending) begin
					if (mag > {{(SAMPLE_BITS-23){1'b0}}, cfg.echo_threshold}) begin
						nxt.latency_sum  = sum_wide[23] ? SUM_MAX : sum_wide[22:0];
						nxt.test_index   = idx_inc;
						if (idx_inc >= TC)
							nxt.running = 1'b0;
						nxt.ping_pending = 1'b0;
					end else if (delta >= {14'd0, cfg.timeout_frames}) begin
						nxt.running      = 1'b0;
						nxt.timeout_flag = 1'b1;
						nxt.ping_pending = 1'b0;
					end
				end
				if (nxt.running && !nxt.ping_pending) begin
					nxt.ping_start   = cur.frame_count;
					nxt.ping_pending = 1'b1;
				end
			end
		end

		play_delta = cur.frame_count - nxt.ping_start;
		nxt.frame_count = cur.frame_count + 32'd1;

		res.out_sample   = (nxt.ping_pending && play_delta < {20'd0, cfg.ping_frames}) ?
			cfg.ping_level : '0;
		res.busy_res     = nxt.running;
		res.finished_ok  = nxt.test_index >= TC;
		res.timed_out    = nxt.timeout_flag;
		res.noise_floor  = nxt.peak_noise;
		res.measurements = nxt.test_index;
		res.latency_sum  = nxt.latency_sum;
	end

endmodule

// ===== rtl/loopback_latency_calibrator.sv =====
// Top level of the loopback latency calibrator: stream ports, registers, state.
// One audio frame per item, one result item per frame. A new item is taken every
// clock cycle unless a result waits on a low m_tready; each item passes an input
// register and then a result register, and the result register feeds m_tvalid and
// m_tdata. The cycle time is set by the per-frame state update: a 32-bit frame
// difference, its compares against the timeout and ping length, and the saturating
// latency sum. latency_average is formed from the registered sum by a constant
// reciprocal multiply.
`include "assert_macros.svh"

module loopback_latency_calibrator import llc_pkg::*; #(
	parameter int unsigned TEST_COUNT = TEST_COUNT_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_TDATA_W-1:0]   s_tdata,  // in_sample
	input  logic                   s_tuser,  // restart
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_sample, busy_res, finished_ok, timed_out, noise_floor, measurements,
	// latency_average, zero fill
	output logic [M_TDATA_W-1:0]   m_tdata
);

	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TEST_COUNT) - 64'd1) / 64'(TEST_COUNT));
	localparam int unsigned PROD_W = 23 + RECIP_W;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	result_t res;
	result_t res_s2;
	logic    valid_s1;
	logic    valid_s2;
	logic    restart_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic    advance;
	logic [PROD_W-1:0] prod;
	logic [AVG_W-1:0]  avg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NOISE_FRAMES:   cfg_q.noise_frames   <= cfg_data[15:0];
				REG_PING_FRAMES:    cfg_q.ping_frames    <= cfg_data[11:0];
				REG_PING_LEVEL:     cfg_q.ping_level     <= $signed(cfg_data[SAMPLE_BITS-1:0]);
				REG_ECHO_THRESHOLD: cfg_q.echo_threshold <= cfg_data[22:0];
				REG_TIMEOUT_FRAMES: cfg_q.timeout_frames <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			restart_s1 <= s_tuser;
			sample_s1  <= $signed(s_tdata[SAMPLE_BITS-1:0]);
		end
	end

	llc_step #(
		.TEST_COUNT(TEST_COUNT)
	) u_step (
		.cfg     (cfg_q),
		.st      (state_q),
		.restart (restart_s1),
		.sample  (sample_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= STATE_RESET;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			res_s2 <= res;
	end

	assign prod = PROD_W'(res_s2.latency_sum) * PROD_W'(RECIP);
	assign avg  = res_s2.finished_ok ? prod[RECIP_SHIFT +: AVG_W] : '0;

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, avg, res_s2.measurements, res_s2.noise_floor,
		res_s2.timed_out, res_s2.finished_ok, res_s2.busy_res, res_s2.out_sample};

	`ASSERT_SAME(a_done_not_timeout, valid_s2, !(res_s2.finished_ok && res_s2.timed_out), "finished and timed out together")
	`ASSERT_SAME(a_meas_bound, valid_s2, res_s2.measurements <= 5'(TEST_COUNT), "measurement count past limit")
	`ASSERT_SAME(a_done_idle, valid_s2 && (res_s2.finished_ok || res_s2.timed_out), !res_s2.busy_res, "busy after run ended")
	`ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(sample_s1), "input item lost under stall")

endmodule
